@@ hw/rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants for the block sparse mat-vec
// opcodes, field widths, pipeline control and result item layout
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int VAL_W     = 32;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 16;
  localparam int SUM_W     = 48;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BLOCK = 2'd2
  } opcode_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       row_end;
    logic       matrix_end;
  } ctl_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] first_result;
    logic signed [VAL_W-1:0] second_result;
    logic [ROW_W-1:0]        row_number;
    logic                    final_row;
  } result_t;

  function automatic logic is_emit(input logic [1:0] op, input logic row_end);
    return row_end && (op == OP_START || op == OP_BLOCK);
  endfunction

endpackage

@@ hw/rtl/bsm_if.sv @@
// ----------------------------------------------------------------------------
// bsm_if: channel interfaces of the block sparse mat-vec
// command items, result items and the mode register write channel
// ----------------------------------------------------------------------------
interface bsm_cmd_if;
  import bsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [COL_W-1:0]        column;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  logic signed [VAL_W-1:0] coef_00;
  logic signed [VAL_W-1:0] coef_01;
  logic signed [VAL_W-1:0] coef_10;
  logic signed [VAL_W-1:0] coef_11;
  logic                    row_end;
  logic                    matrix_end;

  modport source (
    output valid, opcode, column, first_value, second_value,
    output coef_00, coef_01, coef_10, coef_11, row_end, matrix_end,
    input  ready
  );
  modport sink (
    input  valid, opcode, column, first_value, second_value,
    input  coef_00, coef_01, coef_10, coef_11, row_end, matrix_end,
    output ready
  );
endinterface

interface bsm_result_if;
  import bsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] first_result;
  logic signed [VAL_W-1:0] second_result;
  logic [ROW_W-1:0]        row_number;
  logic                    final_row;

  modport source (
    output valid, first_result, second_result, row_number, final_row,
    input  ready
  );
  modport sink (
    input  valid, first_result, second_result, row_number, final_row,
    output ready
  );
endinterface

interface bsm_cfg_if;
  logic valid;
  logic ready;
  logic add_mode;

  modport source (output valid, add_mode, input ready);
  modport sink (input valid, add_mode, output ready);
endinterface

@@ hw/rtl/bsm_xstore.sv @@
// ----------------------------------------------------------------------------
// bsm_xstore: vector store
// one x pair per block column, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bsm_xstore #(
  parameter int  DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [2*bsm_pkg::VAL_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [2*bsm_pkg::VAL_W-1:0] rd_data
);
  import bsm_pkg::*;

  logic [2*VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/bsm_mac.sv @@
// ----------------------------------------------------------------------------
// bsm_mac: block multiply and row accumulate
// product stage, accumulate stage, then output saturation and row numbering
// ----------------------------------------------------------------------------
module bsm_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           add_mode,
  input  bsm_pkg::ctl_t                  s1_ctl,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_coef_00,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_coef_01,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_coef_10,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_coef_11,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_bias_first,
  input  logic signed [bsm_pkg::VAL_W-1:0] s1_bias_second,
  input  logic [2*bsm_pkg::VAL_W-1:0]    s1_x,
  input  logic                           s1_x_ok,
  output logic                           res_valid,
  output bsm_pkg::result_t               res
);
  import bsm_pkg::*;

  localparam int PW = 2 * VAL_W;
  localparam int EW = PW + 1;

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [EW-1:0] v);
    if (&v[EW-1:SUM_W-1] || ~|v[EW-1:SUM_W-1]) begin
      return v[SUM_W-1:0];
    end else if (v[EW-1]) begin
      return {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (&v[SUM_W-1:VAL_W-1] || ~|v[SUM_W-1:VAL_W-1]) begin
      return v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  logic signed [VAL_W-1:0] xe;
  logic signed [VAL_W-1:0] xo;
  ctl_t                    p_ctl;
  ctl_t                    a_ctl;
  logic signed [PW-1:0]    p00;
  logic signed [PW-1:0]    p01;
  logic signed [PW-1:0]    p10;
  logic signed [PW-1:0]    p11;
  logic signed [VAL_W-1:0] p_bias_first;
  logic signed [VAL_W-1:0] p_bias_second;
  logic signed [PW-1:0]    sh00;
  logic signed [PW-1:0]    sh01;
  logic signed [PW-1:0]    sh10;
  logic signed [PW-1:0]    sh11;
  logic signed [SUM_W-1:0] first_sum;
  logic signed [SUM_W-1:0] second_sum;
  logic signed [SUM_W-1:0] first_sum_next;
  logic signed [SUM_W-1:0] second_sum_next;
  logic signed [SUM_W-1:0] first_mid;
  logic signed [SUM_W-1:0] second_mid;
  logic [ROW_W-1:0]        row_counter;

  assign xe = s1_x_ok ? s1_x[VAL_W-1:0] : '0;
  assign xo = s1_x_ok ? s1_x[2*VAL_W-1:VAL_W] : '0;

  // product stage
  always_ff @(posedge clk) begin
    p00           <= s1_coef_00 * xe;
    p01           <= s1_coef_01 * xo;
    p10           <= s1_coef_10 * xe;
    p11           <= s1_coef_11 * xo;
    p_bias_first  <= s1_bias_first;
    p_bias_second <= s1_bias_second;
  end

  // floor scaling
  assign sh00 = p00 >>> FRAC_BITS;
  assign sh01 = p01 >>> FRAC_BITS;
  assign sh10 = p10 >>> FRAC_BITS;
  assign sh11 = p11 >>> FRAC_BITS;

  assign first_mid  = sat48(EW'(first_sum) + EW'(sh00));
  assign second_mid = sat48(EW'(second_sum) + EW'(sh10));

  always_comb begin
    first_sum_next  = first_sum;
    second_sum_next = second_sum;
    if (p_ctl.valid) begin
      case (p_ctl.op)
        OP_START: begin
          first_sum_next  = add_mode ? SUM_W'(p_bias_first) : '0;
          second_sum_next = add_mode ? SUM_W'(p_bias_second) : '0;
        end
        OP_BLOCK: begin
          first_sum_next  = sat48(EW'(first_mid) + EW'(sh01));
          second_sum_next = sat48(EW'(second_mid) + EW'(sh11));
        end
        default: begin
          first_sum_next  = first_sum;
          second_sum_next = second_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl       <= '0;
      a_ctl       <= '0;
      first_sum   <= '0;
      second_sum  <= '0;
      row_counter <= '0;
    end else begin
      p_ctl      <= s1_ctl;
      a_ctl      <= p_ctl;
      first_sum  <= first_sum_next;
      second_sum <= second_sum_next;
      if (res_valid) begin
        row_counter <= a_ctl.matrix_end ? '0 : row_counter + 1'b1;
      end
    end
  end

  // output stage reads the sums the item left behind
  assign res_valid         = a_ctl.valid && is_emit(a_ctl.op, a_ctl.row_end);
  assign res.first_result  = sat32(first_sum);
  assign res.second_result = sat32(second_sum);
  assign res.row_number    = row_counter;
  assign res.final_row     = a_ctl.matrix_end;

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (p_ctl.valid && p_ctl.op == OP_START && !add_mode)
      |=> (first_sum == '0 && second_sum == '0))
    else $error("row start did not clear the sums");

  a_last_row_wraps: assert property (@(posedge clk) disable iff (rst)
    (res_valid && a_ctl.matrix_end) |=> (row_counter == '0))
    else $error("row number not restarted after last row");

endmodule

@@ hw/rtl/bsm_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bsm_out_fifo: result item queue
// holds finished rows while the receiver stalls
// ----------------------------------------------------------------------------
module bsm_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  bsm_pkg::result_t               wr_data,
  output logic                           rd_valid,
  input  logic                           rd_ready,
  output bsm_pkg::result_t               rd_data,
  output logic [bsm_pkg::OUT_CNT_W-1:0]  count
);
  import bsm_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);

  result_t       mem [OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          rd_fire;

  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != OUT_CNT_W'(OUT_DEPTH) || rd_fire))
    else $error("result queue overflow");

endmodule

@@ hw/rtl/block2_sparse_matvec.sv @@
// ----------------------------------------------------------------------------
// block2_sparse_matvec: 2x2 block compressed-row sparse matrix-vector product
//
// cmd carries load, row-start and block items; cfg writes add_mode, 0 for a
// plain product and 1 to start each row from the bias pair in its start item.
// result carries one item per row-closing item: the two saturated sums, the
// row number and the final-row flag.
// A load writes the x store at the edge it is accepted, so a block item may
// use that column from the very next cycle.
// One item is accepted every cycle while cmd.ready is high. A closing item
// passes the x store read, product register and accumulate register; its
// result then shows on result from the next cycle via an 8-entry queue.
// When the receiver stalls, cmd keeps accepting until every queue entry is
// claimed by a pending result; then cmd.ready drops until result drains.
// Reset clears the sums, the row number, add_mode and the queue; the x store
// is not cleared and a column must be loaded before it is used.
// ----------------------------------------------------------------------------
module block2_sparse_matvec #(
  parameter int COLUMN_BLOCKS = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic         clk,
  input  logic         rst,
  bsm_cmd_if.sink      cmd,
  bsm_cfg_if.sink      cfg,
  bsm_result_if.source result
);
  import bsm_pkg::*;

  localparam int DEPTH = (COLUMN_BLOCKS < 2 ** COL_W) ? COLUMN_BLOCKS : 2 ** COL_W;
  localparam int AW    = $clog2(DEPTH);

  logic                    cmd_fire;
  logic                    cmd_emit;
  logic                    in_range;
  logic                    add_mode;
  ctl_t                    s1_ctl;
  logic signed [VAL_W-1:0] s1_coef_00;
  logic signed [VAL_W-1:0] s1_coef_01;
  logic signed [VAL_W-1:0] s1_coef_10;
  logic signed [VAL_W-1:0] s1_coef_11;
  logic signed [VAL_W-1:0] s1_bias_first;
  logic signed [VAL_W-1:0] s1_bias_second;
  logic                    s1_x_ok;
  logic [2*VAL_W-1:0]      x_pair;
  logic                    res_valid;
  result_t                 res;
  result_t                 head;
  logic                    out_fire;
  logic [OUT_CNT_W-1:0]    pending;
  logic [OUT_CNT_W-1:0]    pending_next;
  logic [OUT_CNT_W-1:0]    fifo_count;

  assign cfg.ready = 1'b1;
  assign cmd.ready = pending != OUT_CNT_W'(OUT_DEPTH);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd_emit  = is_emit(cmd.opcode, cmd.row_end);
  assign in_range  = int'(cmd.column) < COLUMN_BLOCKS;
  assign out_fire  = result.valid && result.ready;

  always_comb begin
    case ({cmd_fire && cmd_emit, out_fire})
      2'b10:   pending_next = pending + 1'b1;
      2'b01:   pending_next = pending - 1'b1;
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add_mode     <= 1'b0;
      s1_ctl.valid <= 1'b0;
      pending      <= '0;
    end else begin
      if (cfg.valid) begin
        add_mode <= cfg.add_mode;
      end
      s1_ctl.valid <= cmd_fire;
      pending      <= pending_next;
    end
    s1_ctl.op         <= cmd.opcode;
    s1_ctl.row_end    <= cmd.row_end;
    s1_ctl.matrix_end <= cmd.matrix_end;
  end

  always_ff @(posedge clk) begin
    s1_coef_00        <= cmd.coef_00;
    s1_coef_01        <= cmd.coef_01;
    s1_coef_10        <= cmd.coef_10;
    s1_coef_11        <= cmd.coef_11;
    s1_bias_first     <= cmd.first_value;
    s1_bias_second    <= cmd.second_value;
    s1_x_ok           <= in_range;
  end

  bsm_xstore #(
    .DEPTH (DEPTH)
  ) u_xstore (
    .clk     (clk),
    .wr_en   (cmd_fire && cmd.opcode == OP_LOAD && in_range),
    .wr_addr (cmd.column[AW-1:0]),
    .wr_data ({cmd.second_value, cmd.first_value}),
    .rd_addr (cmd.column[AW-1:0]),
    .rd_data (x_pair)
  );

  bsm_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk            (clk),
    .rst            (rst),
    .add_mode       (add_mode),
    .s1_ctl         (s1_ctl),
    .s1_coef_00     (s1_coef_00),
    .s1_coef_01     (s1_coef_01),
    .s1_coef_10     (s1_coef_10),
    .s1_coef_11     (s1_coef_11),
    .s1_bias_first  (s1_bias_first),
    .s1_bias_second (s1_bias_second),
    .s1_x           (x_pair),
    .s1_x_ok        (s1_x_ok),
    .res_valid      (res_valid),
    .res            (res)
  );

  bsm_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_valid (result.valid),
    .rd_ready (result.ready),
    .rd_data  (head),
    .count    (fifo_count)
  );

  assign result.first_result  = head.first_result;
  assign result.second_result = head.second_result;
  assign result.row_number    = head.row_number;
  assign result.final_row     = head.final_row;

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit count out of range");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("queued results exceed claimed credits");

endmodule

@@ tb/tb_block2_sparse_matvec.sv @@
// ----------------------------------------------------------------------------
// tb_block2_sparse_matvec: self-checking testbench of the 2x2 block sparse
// mat-vec. A directed table covers the extremes, saturation, floor rounding,
// the ignored opcode and flags, and both add modes. Random well-formed
// matrices with noise items follow, then a final stretch with no idling.
// Every result item is compared with its table row or a local predictor;
// outside the final stretch both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_block2_sparse_matvec;
  timeunit 1ns;
  timeprecision 1ps;
  import bsm_pkg::*;

  localparam int FRAC = 16;
  localparam int COLS = 1024;
  localparam int WATCH_LIMIT = 500;
  localparam int SETTLE = 12;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] first_value, second_value;
    logic signed [VAL_W-1:0] coef_00, coef_01, coef_10, coef_11;
    logic                    row_end, matrix_end;
  } cmd_item_t;

  typedef struct packed {
    bit        is_cfg;
    bit        mode;
    bit        typed;
    cmd_item_t item;
    result_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsm_cmd_if    cmd();
  bsm_cfg_if    cfg();
  bsm_result_if result();

  block2_sparse_matvec #(.COLUMN_BLOCKS(COLS), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .result(result)
  );

  logic signed [VAL_W-1:0] x_even [COLS];
  logic signed [VAL_W-1:0] x_odd [COLS];
  bit                      x_loaded [COLS];
  int                      loaded_cols [$];
  longint                  first_acc = 0;
  longint                  second_acc = 0;
  logic [ROW_W-1:0]        row_cnt = '0;
  bit                      mode_bit = 1'b0;
  result_t                 expected_rows [$];
  int                      mismatches = 0;
  int                      work_items = 0;
  int                      gap_pct = 20;
  bit                      steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sx(logic signed [VAL_W-1:0] v);
    return v;
  endfunction

  function automatic longint sat48(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic longint scaled(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic longint row_acc(longint acc, longint a0, longint a1,
                                     longint xe, longint xo);
    acc = sat48(acc + scaled(a0, xe));
    return sat48(acc + scaled(a1, xo));
  endfunction

  function automatic logic signed [VAL_W-1:0] out32(longint v);
    if (v > 64'sd2147483647) return VMAX;
    if (v < -64'sd2147483648) return VMIN;
    return v[VAL_W-1:0];
  endfunction

  task automatic mv_step(input cmd_item_t it, output bit emits, output result_t r);
    longint xe, xo;
    emits = 1'b0;
    r = '0;
    case (it.opcode)
      OP_LOAD: begin
        x_even[it.column] = it.first_value;
        x_odd[it.column] = it.second_value;
        if (!x_loaded[it.column]) begin
          x_loaded[it.column] = 1'b1;
          loaded_cols.push_back(it.column);
        end
        return;
      end
      OP_START: begin
        first_acc = mode_bit ? sx(it.first_value) : 0;
        second_acc = mode_bit ? sx(it.second_value) : 0;
      end
      OP_BLOCK: begin
        xe = sx(x_even[it.column]);
        xo = sx(x_odd[it.column]);
        first_acc = row_acc(first_acc, sx(it.coef_00), sx(it.coef_01), xe, xo);
        second_acc = row_acc(second_acc, sx(it.coef_10), sx(it.coef_11), xe, xo);
      end
      default: return;
    endcase
    if (it.row_end) begin
      emits = 1'b1;
      r.first_result = out32(first_acc);
      r.second_result = out32(second_acc);
      r.row_number = row_cnt;
      r.final_row = it.matrix_end;
      row_cnt = it.matrix_end ? '0 : row_cnt + 1'b1;
    end
  endtask

  task automatic send_item(input cmd_item_t it, input bit typed, input result_t want);
    bit      emits;
    result_t r;
    cmd.valid <= 1'b1;
    cmd.opcode <= it.opcode;
    cmd.column <= it.column;
    cmd.first_value <= it.first_value;
    cmd.second_value <= it.second_value;
    cmd.coef_00 <= it.coef_00;
    cmd.coef_01 <= it.coef_01;
    cmd.coef_10 <= it.coef_10;
    cmd.coef_11 <= it.coef_11;
    cmd.row_end <= it.row_end;
    cmd.matrix_end <= it.matrix_end;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    mv_step(it, emits, r);
    if (emits) expected_rows.push_back(typed ? want : r);
    if (it.opcode != OP_NONE) work_items++;
    if (!steady && $urandom_range(0, 99) < gap_pct) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    cmd.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input bit m);
    cfg.valid <= 1'b1;
    cfg.add_mode <= m;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    mode_bit = m;
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2, 3: return $urandom;
      4: return '0;
      default: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
    endcase
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    it.opcode = $urandom_range(0, 3);
    it.column = $urandom_range(0, COLS - 1);
    it.first_value = rand_val();
    it.second_value = rand_val();
    it.coef_00 = rand_val();
    it.coef_01 = rand_val();
    it.coef_10 = rand_val();
    it.coef_11 = rand_val();
    it.row_end = $urandom_range(0, 1);
    it.matrix_end = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic cmd_item_t cmd_of(logic [1:0] op, logic [COL_W-1:0] col,
      logic signed [VAL_W-1:0] fv, logic signed [VAL_W-1:0] sv,
      logic signed [VAL_W-1:0] c00, logic signed [VAL_W-1:0] c01,
      logic signed [VAL_W-1:0] c10, logic signed [VAL_W-1:0] c11, bit re, bit me);
    cmd_item_t it;
    it.opcode = op;
    it.column = col;
    it.first_value = fv;
    it.second_value = sv;
    it.coef_00 = c00;
    it.coef_01 = c01;
    it.coef_10 = c10;
    it.coef_11 = c11;
    it.row_end = re;
    it.matrix_end = me;
    return it;
  endfunction

  function automatic result_t row_result(logic signed [VAL_W-1:0] f,
      logic signed [VAL_W-1:0] s, logic [ROW_W-1:0] row, bit fin);
    result_t r;
    r.first_result = f;
    r.second_result = s;
    r.row_number = row;
    r.final_row = fin;
    return r;
  endfunction

  function automatic dir_row_t dir_cmd(cmd_item_t it, bit typed, result_t want);
    dir_row_t d;
    d = '0;
    d.item = it;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  function automatic dir_row_t dir_cfg(bit m);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.mode = m;
    return d;
  endfunction

  task automatic send_matrix();
    cmd_item_t it;
    int        nrows, nblk;
    bit        last_row, skip_start, closes;
    repeat ($urandom_range(0, 2)) begin
      it = rand_item();
      it.opcode = OP_LOAD;
      send_item(it, 1'b0, '0);
    end
    nrows = $urandom_range(1, 5);
    closes = ($urandom_range(0, 7) != 0);
    for (int r = 0; r < nrows; r++) begin
      last_row = closes && (r == nrows - 1);
      skip_start = ($urandom_range(0, 9) == 0);
      nblk = $urandom_range(skip_start ? 1 : 0, 4);
      if (!skip_start) begin
        it = rand_item();
        it.opcode = OP_START;
        it.row_end = (nblk == 0);
        if (nblk == 0) it.matrix_end = last_row;
        send_item(it, 1'b0, '0);
      end
      for (int b = 0; b < nblk; b++) begin
        if ($urandom_range(0, 7) == 0) begin
          it = rand_item();
          it.opcode = OP_LOAD;
          send_item(it, 1'b0, '0);
        end
        if ($urandom_range(0, 15) == 0) begin
          it = rand_item();
          it.opcode = OP_NONE;
          send_item(it, 1'b0, '0);
        end
        it = rand_item();
        it.opcode = OP_BLOCK;
        it.column = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
        it.row_end = (b == nblk - 1);
        if (it.row_end) it.matrix_end = last_row;
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: %h %h row %0d final %0d",
                   result.first_result, result.second_result, result.row_number,
                   result.final_row);
      end else begin
        want = expected_rows.pop_front();
        if (result.first_result !== want.first_result ||
            result.second_result !== want.second_result ||
            result.row_number !== want.row_number || result.final_row !== want.final_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row mismatch: expected %h %h row %0d final %0d, got %h %h row %0d final %0d",
                     want.first_result, want.second_result, want.row_number, want.final_row,
                     result.first_result, result.second_result, result.row_number,
                     result.final_row);
        end
      end
    end
  end

  // receiver stalls, stall rate drawn anew every window
  initial begin : drive_ready
    int stall, stall_pct, win;
    stall = 0;
    stall_pct = 0;
    win = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (win == 0) begin
        win = 256;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      win--;
      if (steady) begin
        result.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        result.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall = $urandom_range(1, 7) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((cmd.valid && cmd.ready) || (cfg.valid && cfg.ready) ||
        (result.valid && result.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("tb_block2_sparse_matvec NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t  dir [$];
    int        start;
    bit        forced;
    cmd.valid <= 1'b0;
    cmd.opcode <= '0;
    cmd.column <= '0;
    cmd.first_value <= '0;
    cmd.second_value <= '0;
    cmd.coef_00 <= '0;
    cmd.coef_01 <= '0;
    cmd.coef_10 <= '0;
    cmd.coef_11 <= '0;
    cmd.row_end <= 1'b0;
    cmd.matrix_end <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.add_mode <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // plain mode after reset: start items give zero sums
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, ONE, ONE, 0, 0, 0, 0, 1, 0), 1,
                          row_result(0, 0, 0, 0)));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, VMAX, VMIN, 0, 0, 0, 0, 1, 1), 1,
                          row_result(0, 0, 1, 1)));
    dir.push_back(dir_cmd(cmd_of(OP_LOAD, 0, VMAX, VMAX, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_LOAD, 1023, VMIN, VMIN, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_LOAD, 5, ONE, 2 * ONE, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 0, 0, 0, VMAX, VMAX, VMAX, VMAX, 1, 0), 1,
                          row_result(VMAX, VMAX, 0, 0)));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 0, 0, 0, VMIN, VMIN, VMIN, VMIN, 1, 0), 1,
                          row_result(VMIN, VMIN, 1, 0)));
    // 48-bit saturation, then a further block on the saturated sums
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 1023, 0, 0, VMIN, VMIN, VMIN, VMIN, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 1023, 0, 0, VMIN, VMIN, VMIN, VMIN, 1, 0), 1,
                          row_result(VMAX, VMAX, 2, 0)));
    // block without start
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 5, 0, 0, ONE, -ONE, 3 * ONE, 0, 1, 0), 0, '0));
    // flags on load, ignored opcode, matrix end without row end
    dir.push_back(dir_cmd(cmd_of(OP_LOAD, 7, 32'sh0003_8000, 32'shFFFF_FFFF, 0, 0, 0, 0, 1, 1),
                          0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_NONE, 3, VMAX, VMIN, ONE, ONE, ONE, ONE, 1, 1), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0));
    // floor rounding of negative products
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 7, 0, 0, 32'sh0000_8000, 32'sh0000_8000,
                                 32'shFFFF_0000, 32'sh7FFF_0000, 1, 1), 0, '0));
    dir.push_back(dir_cfg(1'b1));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, VMAX, VMIN, 0, 0, 0, 0, 1, 0), 1,
                          row_result(VMAX, VMIN, 0, 0)));
    dir.push_back(dir_cmd(cmd_of(OP_START, 0, 32'sh0001_8000, 32'shFFFD_8000,
                                 0, 0, 0, 0, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 5, 0, 0, 32'shFFFF_0000, 32'sh0000_4000,
                                 32'shFFFE_8000, ONE, 0, 0), 0, '0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 1023, 0, 0, 32'sh0000_0001, 32'shFFFF_FFFF,
                                 32'sh0000_0100, 32'sh0000_0010, 1, 1), 0, '0));
    dir.push_back(dir_cfg(1'b0));
    dir.push_back(dir_cmd(cmd_of(OP_BLOCK, 0, 0, 0, 0, 0, 0, 0, 1, 0), 0, '0));

    foreach (dir[i]) begin
      if (dir[i].is_cfg) begin
        wait_idle();
        cfg_write(dir[i].mode);
      end else begin
        send_item(dir[i].item, dir[i].typed, dir[i].want);
      end
    end

    start = work_items;
    forced = 1'b0;
    while (work_items - start < 700) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (!forced && work_items - start >= 350) begin
        forced = 1'b1;
        wait_idle();
        cfg_write(!mode_bit);
      end else if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        cfg_write($urandom_range(0, 1));
      end
      send_matrix();
    end

    steady = 1'b1;
    start = work_items;
    while (work_items - start < 100) send_matrix();

    cmd.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("tb_block2_sparse_matvec OK");
    end else begin
      $display("tb_block2_sparse_matvec NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_if.sv
hw/rtl/bsm_xstore.sv
hw/rtl/bsm_mac.sv
hw/rtl/bsm_out_fifo.sv
hw/rtl/block2_sparse_matvec.sv
tb/tb_block2_sparse_matvec.sv
